// ===== rtl/slsfr_pkg.sv =====
// Package for the sync/length/checksum frame receiver.
// Holds the shared widths, sync constants, status codes and result type.
// No dependencies.
`timescale 1ns / 1ps

package slsfr_pkg;

  // Default bound on the frame length.
  localparam int MAX_PAYLOAD_DEF = 64;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 7;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_GOOD       = 3'd1,
    ST_BAD_SUM    = 3'd2,
    ST_BAD_HEADER = 3'd3,
    ST_OVERFLOW   = 3'd4
  } frame_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic [IDX_W-1:0]  byte_index;
    frame_status_t     frame_status;
  } result_t;

endpackage

// ===== rtl/slsfr_tracker.sv =====
// Frame tracker: holds the frame state and works out one result per byte.
// Depends on slsfr_pkg.
`timescale 1ns / 1ps

module slsfr_tracker #(
  parameter int MAX_PAYLOAD = slsfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [slsfr_pkg::BYTE_W-1:0]  rx_byte,
  output slsfr_pkg::result_t            result
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 4);
  localparam logic [CNT_W-1:0] OVF_IDX = CNT_W'(MAX_PAYLOAD + 3);

  logic [CNT_W-1:0]             fill_count_r, fill_count_nxt;
  logic                         sync_ok_r, sync_ok_nxt;
  logic [slsfr_pkg::BYTE_W-1:0] frame_len_r, frame_len_nxt;
  logic [slsfr_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  slsfr_pkg::frame_status_t     status;
  logic [7:0]                   idx_ext;
  logic [8:0]                   end_idx;
  logic                         in_body;

  assign idx_ext = 8'(fill_count_r);
  assign end_idx = 9'(frame_len_r) + 9'd2;
  assign in_body = fill_count_r >= CNT_W'(3);

  always_comb begin
    status         = slsfr_pkg::ST_NONE;
    fill_count_nxt = fill_count_r;
    sync_ok_nxt    = sync_ok_r;
    frame_len_nxt  = frame_len_r;
    sum_nxt        = sum_r;
    if (fill_count_r >= OVF_IDX) begin
      status         = slsfr_pkg::ST_OVERFLOW;
      fill_count_nxt = '0;
      sum_nxt        = '0;
    end else if (fill_count_r == '0 && rx_byte != slsfr_pkg::SYNC_FIRST) begin
      fill_count_nxt = '0;
      sum_nxt        = '0;
    end else begin
      if (fill_count_r == CNT_W'(1)) begin
        sync_ok_nxt = (rx_byte == slsfr_pkg::SYNC_SECOND);
      end
      if (fill_count_r == CNT_W'(2)) begin
        frame_len_nxt = rx_byte;
      end
      if (in_body && !sync_ok_r) begin
        status         = slsfr_pkg::ST_BAD_HEADER;
        fill_count_nxt = '0;
        sum_nxt        = '0;
      end else if (in_body && 9'(fill_count_r) >= end_idx) begin
        status         = (sum_r == rx_byte) ? slsfr_pkg::ST_GOOD : slsfr_pkg::ST_BAD_SUM;
        fill_count_nxt = '0;
        sum_nxt        = '0;
      end else begin
        sum_nxt        = sum_r + rx_byte;
        fill_count_nxt = fill_count_r + CNT_W'(1);
      end
    end
  end

  assign result.byte_out     = rx_byte;
  assign result.byte_index   = idx_ext[slsfr_pkg::IDX_W-1:0];
  assign result.frame_status = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      sync_ok_r    <= 1'b0;
      frame_len_r  <= '0;
      sum_r        <= '0;
    end else if (accept) begin
      fill_count_r <= fill_count_nxt;
      sync_ok_r    <= sync_ok_nxt;
      frame_len_r  <= frame_len_nxt;
      sum_r        <= sum_nxt;
    end
  end

endmodule

// ===== rtl/slsfr_outbuf.sv =====
// Two-entry result buffer: a main output register backed by a skid register.
// Depends on slsfr_pkg.
`timescale 1ns / 1ps

module slsfr_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  slsfr_pkg::result_t wr_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output slsfr_pkg::result_t out_data
);

  logic               main_v_r, main_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  slsfr_pkg::result_t main_d_r, main_d_nxt;
  slsfr_pkg::result_t skid_d_r, skid_d_nxt;
  logic               take;

  assign take = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (take) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (wr_en) begin
      if (!main_v_r || take) begin
        main_d_nxt = wr_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = wr_data;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

endmodule

// ===== rtl/sync_length_sum_frame_receiver_top.sv =====
// Top level of the sync/length/checksum frame receiver.
// Depends on slsfr_pkg, slsfr_tracker and slsfr_outbuf.
`timescale 1ns / 1ps
//
//  Channel  Ports                                       Direction  Moves
//  -------  ------------------------------------------  ---------  -----------------------
//  in_      in_valid, in_stall, in_rx_byte              sink       one received byte
//  out_     out_valid, out_stall, out_byte_out,         source     byte, index and status
//           out_byte_index, out_frame_status
//
// Every input transfer produces exactly one result transfer, from a registered result.
// A byte can be taken on every clock while the skid register is empty; the sustained
// rate is one byte per cycle while the output is not stalled, set by the frame tracker.
// Reset is synchronous and active low; it clears the frame state and empties
// the result buffer, and the input is stalled while reset is held.
// A result register plus a skid register sit on the output, so an input
// transfer is taken while a result waits; apart from reset, in_stall rises only once
// both hold results, and otherwise it comes straight from a register.

module sync_length_sum_frame_receiver_top #(
  parameter int MAX_PAYLOAD = slsfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [slsfr_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [slsfr_pkg::BYTE_W-1:0]  out_byte_out,
  output logic [slsfr_pkg::IDX_W-1:0]   out_byte_index,
  output logic [2:0]                    out_frame_status
);

  logic               accept;
  logic               buf_full;
  slsfr_pkg::result_t result;
  slsfr_pkg::result_t out_data;

  // The buffer's skid entry being occupied is the only reason to hold off
  // the sender, apart from reset.
  assign in_stall = buf_full || !rst_n;
  assign accept   = in_valid && !in_stall;

  // The tracker updates the frame state on each accepted byte and produces
  // the matching result in the same cycle.
  slsfr_tracker #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .result  (result)
  );

  slsfr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept),
    .wr_data   (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_byte_out     = out_data.byte_out;
  assign out_byte_index   = out_data.byte_index;
  assign out_frame_status = 3'(out_data.frame_status);

endmodule

// ===== rtl/slsfr_checker.sv =====
// Port-level checks for the frame receiver, bound onto its top level.
// Depends on slsfr_pkg and sync_length_sum_frame_receiver_top.
`timescale 1ns / 1ps

module slsfr_checker #(
  parameter int MAX_PAYLOAD = slsfr_pkg::MAX_PAYLOAD_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [slsfr_pkg::BYTE_W-1:0] in_rx_byte,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [slsfr_pkg::BYTE_W-1:0] out_byte_out,
  input logic [slsfr_pkg::IDX_W-1:0]  out_byte_index,
  input logic [2:0]                   out_frame_status
);

  localparam bit IDX_FITS = (MAX_PAYLOAD + 3) < (1 << slsfr_pkg::IDX_W);
  localparam logic [slsfr_pkg::IDX_W-1:0] FIRST_END_IDX = 3;

  // A stalled input byte stays presented and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("input byte withdrawn or changed while stalled");

  // A stalled result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte_out) && $stable(out_byte_index)
                              && $stable(out_frame_status))
    else $error("stalled result changed");

  // The input is only held off when results are backed up.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // A frame can only end once the length byte and a checksum have been seen.
  a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
    IDX_FITS && out_valid && (out_frame_status == 3'(slsfr_pkg::ST_GOOD)
      || out_frame_status == 3'(slsfr_pkg::ST_BAD_SUM))
    |-> out_byte_index >= FIRST_END_IDX)
    else $error("frame end reported before the checksum position");

endmodule

bind sync_length_sum_frame_receiver_top slsfr_checker #(
  .MAX_PAYLOAD (MAX_PAYLOAD)
) u_slsfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_rx_byte       (in_rx_byte),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_byte_out     (out_byte_out),
  .out_byte_index   (out_byte_index),
  .out_frame_status (out_frame_status)
);

// ===== test/testbench.sv =====
// Self-checking testbench for sync_length_sum_frame_receiver_top.
// Depends on slsfr_pkg and the receiver RTL; it drives bytes in and checks each
// result transfer against its own frame predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int BYTE_W      = slsfr_pkg::BYTE_W;
  localparam int IDX_W       = slsfr_pkg::IDX_W;
  localparam int MAX_PAYLOAD = slsfr_pkg::MAX_PAYLOAD_DEF;
  localparam int N_ITEMS     = 650;

  // One row of the directed table. Where typed is set, the expected result is
  // written into the row; otherwise the predictor supplies it. A row with
  // reps above one sends the same byte that many times.
  typedef struct {
    logic [BYTE_W-1:0]        b;
    int                       reps;
    bit                       typed;
    logic [IDX_W-1:0]         idx;
    slsfr_pkg::frame_status_t st;
  } dir_row_t;

  // One byte queued for the input channel.
  typedef struct {
    logic [BYTE_W-1:0]  b;
    bit                 typed;
    slsfr_pkg::result_t want;
  } byte_item_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte_out;
  logic [IDX_W-1:0]  out_byte_index;
  logic [2:0]        out_frame_status;

  // Predictor state: a copy of the receiver's frame tracking.
  int                frame_fill  = 0;
  logic [BYTE_W-1:0] frame_sync2 = '0;
  logic [BYTE_W-1:0] frame_len   = '0;
  logic [BYTE_W-1:0] frame_sum   = '0;

  byte_item_t         tx_bytes[$];
  byte_item_t         cur_item;
  slsfr_pkg::result_t pending_results[$];
  int         n_taken  = 0;
  int         n_errors = 0;
  int         in_idle_pct  = 16;
  int         out_idle_pct = 75;

  sync_length_sum_frame_receiver_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_byte_index   (out_byte_index),
    .out_frame_status (out_frame_status)
  );

  always #5 clk = ~clk;

  // Works out the result that one received byte causes and advances the
  // predicted frame state. The overflow bound is tested first, then noise at
  // the start of a frame, then the late test of the second sync byte, and only
  // then the end of the frame.
  function automatic slsfr_pkg::result_t frame_step(input logic [BYTE_W-1:0] b);
    slsfr_pkg::result_t r;
    int                 idx;
    idx = frame_fill;
    r.byte_out     = b;
    r.byte_index   = IDX_W'(idx);
    r.frame_status = slsfr_pkg::ST_NONE;
    if (idx + 1 >= MAX_PAYLOAD + 4) begin
      r.frame_status = slsfr_pkg::ST_OVERFLOW;
      frame_fill = 0;
      frame_sum  = '0;
    end else if (idx == 0 && b != slsfr_pkg::SYNC_FIRST) begin
      frame_fill = 0;
      frame_sum  = '0;
    end else begin
      if (idx == 1) frame_sync2 = b;
      if (idx == 2) frame_len = b;
      if (idx >= 3 && frame_sync2 != slsfr_pkg::SYNC_SECOND) begin
        r.frame_status = slsfr_pkg::ST_BAD_HEADER;
        frame_fill = 0;
        frame_sum  = '0;
      end else if (idx >= 3 && idx >= int'(frame_len) + 2) begin
        r.frame_status = (frame_sum == b) ? slsfr_pkg::ST_GOOD : slsfr_pkg::ST_BAD_SUM;
        frame_fill = 0;
        frame_sum  = '0;
      end else begin
        frame_sum  = frame_sum + b;
        frame_fill = idx + 1;
      end
    end
    return r;
  endfunction

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    byte_item_t it;
    it.b     = b;
    it.typed = 1'b0;
    it.want  = '0;
    tx_bytes.push_back(it);
  endtask

  // The receiver side stalls at random; the share is set per phase by the
  // stimulus process. Stall changes only at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  // Both channels are sampled at the rising edge, where the inputs have been
  // steady since the falling edge and the block's registers still hold their
  // values from before the edge. An input transfer is predicted before the
  // result transfer of the same edge is checked.
  always @(posedge clk) begin : monitor
    slsfr_pkg::result_t want;
    slsfr_pkg::result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = frame_step(cur_item.b);
        if (cur_item.typed) want = cur_item.want;
        pending_results.push_back(want);
        n_taken++;
      end
      if (out_valid && !out_stall) begin
        got.byte_out     = out_byte_out;
        got.byte_index   = out_byte_index;
        got.frame_status = slsfr_pkg::frame_status_t'(out_frame_status);
        if (pending_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected: %s %02h %0d %0d",
                   $time, "byte, index, status", got.byte_out, got.byte_index,
                   got.frame_status);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected byte %02h index %0d status %0d,",
                     $time, want.byte_out, want.byte_index, want.frame_status);
            $display("%0t:           got byte %02h index %0d status %0d",
                     $time, got.byte_out, got.byte_index, got.frame_status);
            n_errors++;
          end
        end
      end
    end
  end

  // Stimulus, pacing and the end of the run.
  initial begin : stimulus
    dir_row_t          dir_rows [19];
    byte_item_t        it;
    int                kind;
    int                pick;
    int                len;
    int                n_body;
    int                seen;
    logic [BYTE_W-1:0] s2;
    logic [BYTE_W-1:0] sum;

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;

    // Directed part: noise before a frame, a good frame with length zero, a
    // bad checksum with length one, a wrong second sync byte caught at the
    // fourth byte, a short good frame, and an oversized frame that is aborted
    // at the bound.
    dir_rows = '{
      '{8'h00, 1, 1'b1, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'hFF, 1, 1'b1, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'hAA, 1, 1'b1, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'h55, 1, 1'b1, 7'd1,  slsfr_pkg::ST_NONE},
      '{8'h00, 1, 1'b1, 7'd2,  slsfr_pkg::ST_NONE},
      '{8'hFF, 1, 1'b1, 7'd3,  slsfr_pkg::ST_GOOD},
      '{8'hAA, 1, 1'b1, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'h55, 1, 1'b1, 7'd1,  slsfr_pkg::ST_NONE},
      '{8'h01, 1, 1'b1, 7'd2,  slsfr_pkg::ST_NONE},
      '{8'h12, 1, 1'b1, 7'd3,  slsfr_pkg::ST_BAD_SUM},
      '{8'hAA, 1, 1'b0, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'h00, 1, 1'b0, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'h05, 1, 1'b0, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'h07, 1, 1'b1, 7'd3,  slsfr_pkg::ST_BAD_HEADER},
      '{8'hAA, 1, 1'b0, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'h55, 1, 1'b0, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'h02, 1, 1'b0, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'h33, 1, 1'b0, 7'd0,  slsfr_pkg::ST_NONE},
      '{8'h34, 1, 1'b0, 7'd0,  slsfr_pkg::ST_NONE}
    };
    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        it.b                 = dir_rows[i].b;
        it.typed             = dir_rows[i].typed;
        it.want.byte_out     = dir_rows[i].b;
        it.want.byte_index   = dir_rows[i].idx;
        it.want.frame_status = dir_rows[i].st;
        tx_bytes.push_back(it);
      end
    end
    // The oversized frame: length 65, so the byte at index 67 meets the bound
    // before it could ever be taken as the checksum.
    queue_byte(slsfr_pkg::SYNC_FIRST);
    queue_byte(slsfr_pkg::SYNC_SECOND);
    queue_byte(8'(MAX_PAYLOAD + 1));
    repeat (MAX_PAYLOAD) queue_byte(8'hFF);
    it.b                 = 8'hFF;
    it.typed             = 1'b1;
    it.want.byte_out     = 8'hFF;
    it.want.byte_index   = IDX_W'(MAX_PAYLOAD + 3);
    it.want.frame_status = slsfr_pkg::ST_OVERFLOW;
    tx_bytes.push_back(it);

    // Random part: mostly well-formed frames with random content and mostly
    // short lengths, with noise, broken headers and oversized frames mixed in.
    while (tx_bytes.size() < N_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
      end else if (kind < 18) begin
        queue_byte(slsfr_pkg::SYNC_FIRST);
        do s2 = 8'($urandom); while (s2 == slsfr_pkg::SYNC_SECOND);
        queue_byte(s2);
        queue_byte(8'($urandom));
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
      end else if (kind < 21) begin
        queue_byte(slsfr_pkg::SYNC_FIRST);
        queue_byte(slsfr_pkg::SYNC_SECOND);
        queue_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
        repeat (MAX_PAYLOAD + 1) queue_byte(8'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      len = $urandom_range(0, 12);
        else if (pick < 95) len = $urandom_range(13, 40);
        else                len = $urandom_range(41, MAX_PAYLOAD);
        sum = slsfr_pkg::SYNC_FIRST + slsfr_pkg::SYNC_SECOND + 8'(len);
        queue_byte(slsfr_pkg::SYNC_FIRST);
        queue_byte(slsfr_pkg::SYNC_SECOND);
        queue_byte(8'(len));
        // The checksum sits at index max(3, length+2).
        n_body = (len < 2) ? 0 : len - 1;
        repeat (n_body) begin
          s2 = 8'($urandom);
          sum = sum + s2;
          queue_byte(s2);
        end
        if ($urandom_range(0, 4) == 0) sum = sum ^ 8'($urandom_range(1, 255));
        queue_byte(sum);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Each byte waits out a random gap, then stays presented until its
    // transfer is seen. Idling moves from a busy receiver to a busy sender,
    // and the last third runs with no idling at all.
    foreach (tx_bytes[i]) begin
      if (i == tx_bytes.size() / 3) begin
        in_idle_pct  = 75;
        out_idle_pct = 16;
      end
      if (i == 2 * tx_bytes.size() / 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < in_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      cur_item = tx_bytes[i];
      in_valid   <= 1'b1;
      in_rx_byte <= tx_bytes[i].b;
      seen = n_taken;
      do @(negedge clk); while (n_taken == seen);
    end
    in_valid <= 1'b0;

    // The run waits until every expected result has been seen; spare cycles after that
    // catch any stray transfer after the last expected one.
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      n_errors++;
    end

    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of several hundred bytes
  // with heavy stalling on either side.
  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/slsfr_pkg.sv
rtl/slsfr_tracker.sv
rtl/slsfr_outbuf.sv
rtl/sync_length_sum_frame_receiver_top.sv
rtl/slsfr_checker.sv
test/testbench.sv
